// File: hdl/rpa_pkg.sv
package rpa_pkg;

    localparam int ADDR_W        = 39;
    localparam int CNT_W         = 8;
    localparam int STATUS_W      = 3;
    localparam int CMD_W         = 2;
    localparam int S_TDATA_W     = 40;
    localparam int S_TUSER_W     = CMD_W;
    localparam int M_TDATA_W     = 56;
    localparam int DEF_PAGES     = 32768;
    localparam int DEF_PAGE_SHIFT = 12;

    localparam logic [ADDR_W-1:0] BASE_RESET = 39'h00_8000_0000;
    localparam logic [CNT_W-1:0]  CNT_MAX    = 8'hFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_ADDREF = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_EMPTY      = 3'd1,
        ST_OUTSIDE    = 3'd2,
        ST_MISALIGNED = 3'd3,
        ST_SHARED     = 3'd4,
        ST_SATURATED  = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_FETCH,
        S_UPDATE
    } state_t;

    typedef struct packed {
        logic clear_wr;
        logic load_in;
        logic decode;
        logic fetch;
        logic update;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic out_free;
    } ctrl_status_t;

endpackage

// File: hdl/rpa_ctrl.sv
module rpa_ctrl
    import rpa_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  ctrl_status_t stat,
    output ctrl_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                if (stat.clear_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: state_next = S_FETCH;
            S_FETCH:  state_next = S_UPDATE;
            S_UPDATE: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_CLEAR;
        endcase
    end

    always_comb begin
        s_tready     = (state_reg == S_IDLE);
        cmd.clear_wr = (state_reg == S_CLEAR);
        cmd.load_in  = (state_reg == S_IDLE) && s_tvalid;
        cmd.decode   = (state_reg == S_DECODE);
        cmd.fetch    = (state_reg == S_FETCH);
        cmd.update   = (state_reg == S_UPDATE) && stat.out_free;
    end

endmodule

// File: hdl/rpa_datapath.sv
module rpa_datapath
    import rpa_pkg::*;
#(
    parameter int PAGES      = DEF_PAGES,
    parameter int PAGE_SHIFT = DEF_PAGE_SHIFT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [ADDR_W-1:0]    cfg_wdata,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    input  ctrl_cmd_t            cmd,
    output ctrl_status_t         stat
);

    localparam int IW   = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int DW   = $clog2(PAGES + 1);
    localparam int PG_W = ADDR_W - PAGE_SHIFT;
    localparam logic [PG_W-1:0] PAGES_PG = PG_W'(PAGES);
    localparam logic [DW-1:0]   PAGES_D  = DW'(PAGES);
    localparam logic [IW-1:0]   LAST_IDX = IW'(PAGES - 1);

    // Free stack and count memories.
    logic [IW-1:0]    stack_mem [PAGES];
    logic [CNT_W-1:0] count_mem [PAGES];

    logic [ADDR_W-1:0] base_reg;
    logic [DW-1:0]     depth_reg;
    logic [DW-1:0]     min_depth_reg;
    logic [IW-1:0]     clr_cnt_reg;
    logic              m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    cmd_t              cmd_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [IW-1:0]     idx_reg;
    logic              outside_reg;
    logic              empty_reg;
    logic              use_mem_reg;
    logic [IW-1:0]     stk_pos_reg;
    logic [IW-1:0]     stk_rd_reg;
    logic [CNT_W-1:0]  cnt_rd_reg;
    logic [ADDR_W-1:0] alloc_addr_reg;

    logic [ADDR_W-1:0] base_al;
    logic [ADDR_W-1:0] diff;
    logic [PG_W-1:0]   pg;
    logic              below;
    logic [DW-1:0]     top_d;
    logic [IW-1:0]     fetch_idx;

    logic [CNT_W-1:0]  new_cnt;
    logic [ADDR_W-1:0] res_addr;
    status_t           res_status;
    logic              cnt_we;
    logic              push;

    assign base_al = {base_reg[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
    assign diff    = addr_reg - base_al;
    assign pg      = diff[ADDR_W-1:PAGE_SHIFT];
    assign below   = addr_reg < base_al;
    assign top_d   = depth_reg - DW'(1);
    assign fetch_idx = (cmd_reg == CMD_ALLOC) ? (use_mem_reg ? stk_rd_reg : stk_pos_reg)
                                              : idx_reg;

    assign stat.clear_done = cmd.clear_wr && (clr_cnt_reg == LAST_IDX);
    assign stat.out_free   = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg      <= BASE_RESET;
            depth_reg     <= PAGES_D;
            min_depth_reg <= PAGES_D;
            clr_cnt_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                base_reg <= cfg_wdata;
            end
            if (cmd.clear_wr) begin
                clr_cnt_reg <= clr_cnt_reg + IW'(1);
            end
            if (cmd.decode && (cmd_reg == CMD_ALLOC) && (depth_reg != '0)) begin
                depth_reg <= top_d;
                if (top_d < min_depth_reg) begin
                    min_depth_reg <= top_d;
                end
            end else if (push) begin
                depth_reg <= depth_reg + DW'(1);
            end
            if (cmd.update) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Stack positions below the lowest depth ever reached were never written, so
    // the position itself is taken as their entry in place of the memory read.
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            cmd_reg  <= cmd_t'(s_tuser);
            addr_reg <= s_tdata[ADDR_W-1:0];
        end
        if (cmd.decode) begin
            outside_reg <= below || (pg >= PAGES_PG);
            idx_reg     <= pg[IW-1:0];
            empty_reg   <= (depth_reg == '0);
            stk_pos_reg <= top_d[IW-1:0];
            use_mem_reg <= (top_d >= min_depth_reg);
        end
        if (cmd.fetch) begin
            alloc_addr_reg <= base_al + (ADDR_W'(fetch_idx) << PAGE_SHIFT);
            idx_reg        <= fetch_idx;
        end
        if (cmd.update) begin
            m_tdata_reg <= {{(M_TDATA_W - ADDR_W - CNT_W - STATUS_W){1'b0}},
                            res_status, new_cnt, res_addr};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.decode) begin
            stk_rd_reg <= stack_mem[top_d[IW-1:0]];
        end
        if (push) begin
            stack_mem[depth_reg[IW-1:0]] <= idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fetch) begin
            cnt_rd_reg <= count_mem[fetch_idx];
        end
        if (cmd.clear_wr) begin
            count_mem[clr_cnt_reg] <= '0;
        end else if (cnt_we) begin
            count_mem[idx_reg] <= new_cnt;
        end
    end

    always_comb begin
        new_cnt    = '0;
        res_addr   = '0;
        res_status = ST_OK;
        cnt_we     = 1'b0;
        push       = 1'b0;
        unique case (cmd_reg)
            CMD_ALLOC: begin
                if (empty_reg) begin
                    res_status = ST_EMPTY;
                end else begin
                    res_addr = alloc_addr_reg;
                    if (cnt_rd_reg == CNT_MAX) begin
                        res_status = ST_SATURATED;
                        new_cnt    = CNT_MAX;
                    end else begin
                        new_cnt = cnt_rd_reg + CNT_W'(1);
                        cnt_we  = cmd.update;
                    end
                end
            end
            CMD_ADDREF: begin
                if (outside_reg) begin
                    res_status = ST_OUTSIDE;
                end else if (cnt_rd_reg == CNT_MAX) begin
                    res_status = ST_SATURATED;
                    new_cnt    = CNT_MAX;
                end else begin
                    new_cnt = cnt_rd_reg + CNT_W'(1);
                    cnt_we  = cmd.update;
                end
            end
            CMD_FREE: begin
                if (outside_reg) begin
                    res_status = ST_OUTSIDE;
                end else begin
                    new_cnt = (cnt_rd_reg != '0) ? cnt_rd_reg - CNT_W'(1) : '0;
                    cnt_we  = cmd.update;
                    if (new_cnt != '0) begin
                        res_status = ST_SHARED;
                    end else if (addr_reg[PAGE_SHIFT-1:0] != '0) begin
                        res_status = ST_MISALIGNED;
                    end else begin
                        // A push onto a full stack is dropped.
                        push = cmd.update && (depth_reg < PAGES_D);
                    end
                end
            end
            default: begin
                res_status = ST_OK;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: hdl/refcounted_page_allocator_core.sv
// Page frame allocator with 8-bit reference counts per page.
// Input channel (s_): s_tuser carries the command (allocate, free, add
// reference) and s_tdata the page byte address. Each word yields exactly one
// result word on the m_ channel with the allocated address, the page's count
// after the command and a status code.
// The region base is written through cfg_we/cfg_wdata; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// Timing: an accepted word is decoded while its stack entry is read, then its
// count is read, both from single-port memories, then the count is written back
// and the result registered. The next word is accepted only after the previous
// one has been written back.
// After reset the count memory is cleared one page per cycle, all PAGES pages
// (32768 by default); s_tready stays low during that pass.
// The result sits in an output register: if the receiver stalls, the block
// still takes the next word and works it up to the write-back, where it waits
// until the previous result has been taken.
module refcounted_page_allocator_core
    import rpa_pkg::*;
#(
    parameter int PAGES      = DEF_PAGES,
    parameter int PAGE_SHIFT = DEF_PAGE_SHIFT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [ADDR_W-1:0]    cfg_wdata,    // region_base
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,      // page_address[38:0], zero pad
    input  logic [S_TUSER_W-1:0] s_tuser,      // cmd[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata       // alloc_address, ref_count, status, zero pad
);

    ctrl_cmd_t    cmd;
    ctrl_status_t stat;

    rpa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rpa_datapath #(
        .PAGES      (PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// File: hdl/rpa_checker.sv
module rpa_checker
    import rpa_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    localparam int ST_LO = ADDR_W + CNT_W;

    // Reset empties the output register.
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // One word at a time: acceptance closes the input until the word is done.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after acceptance");

    // Only a successful or saturated allocate hands out an address.
    a_addr_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[ADDR_W-1:0] != '0) |->
            (m_tdata[ST_LO+STATUS_W-1:ST_LO] == ST_OK) ||
            (m_tdata[ST_LO+STATUS_W-1:ST_LO] == ST_SATURATED))
        else $error("address given with failing status");

endmodule

bind refcounted_page_allocator_core rpa_checker u_rpa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
